### sv/acp_pkg.sv
// Package for the ADC-count-to-power calibration block.
// Holds the field widths, the calibration tables and the words passed between cells.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package acp_pkg;

  // Field and datapath widths.
  localparam int COUNT_W    = 12;
  localparam int OUT_W      = 14;
  localparam int SEG_W      = 4;
  localparam int TABLE_ROWS = 16;
  localparam int SLOPE_W    = 10;
  localparam int SCALE_W    = 10;
  localparam int DIV_W      = COUNT_W + SCALE_W;
  // The top dividend bits are always below the smallest slope, so only the
  // low QUOT_W bits can produce quotient bits.
  localparam int QUOT_W     = 15;
  localparam int HEAD_W     = DIV_W - QUOT_W;
  localparam int REM_W      = SLOPE_W;
  localparam int SUM_W      = QUOT_W + 1;

  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(1000);

  // Calibration: upper threshold, slope and intercept for each segment.
  // Rows past the tenth repeat the last segment.
  localparam logic [COUNT_W-1:0] SEG_LIMIT [TABLE_ROWS] = '{
    12'd1288, 12'd1548, 12'd1704, 12'd1812, 12'd1897, 12'd1967, 12'd2164, 12'd2301,
    12'd2411, 12'd2505, 12'd2505, 12'd2505, 12'd2505, 12'd2505, 12'd2505, 12'd2505
  };

  localparam logic [SLOPE_W-1:0] SEG_SLOPE [TABLE_ROWS] = '{
    10'd249, 10'd356, 10'd374, 10'd388, 10'd400, 10'd402, 10'd435, 10'd460,
    10'd500, 10'd553, 10'd553, 10'd553, 10'd553, 10'd553, 10'd553, 10'd553
  };

  localparam logic signed [OUT_W-1:0] SEG_OFFSET [TABLE_ROWS] = '{
    -14'sd5418, -14'sd3810, -14'sd3602, -14'sd3431, -14'sd3289, -14'sd3261,
    -14'sd2877, -14'sd2601, -14'sd2189, -14'sd1725, -14'sd1725, -14'sd1725,
    -14'sd1725, -14'sd1725, -14'sd1725, -14'sd1725
  };

  // Word passed along the segment search chain.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               found;
    logic [SEG_W-1:0]   seg;
  } seg_word_t;

  // Word passed along the divider chain. The low bits of the dividend are
  // shifted out at the top while quotient bits enter at the bottom.
  typedef struct packed {
    logic [REM_W-1:0]         rem;
    logic [QUOT_W-1:0]        low;
    logic [SLOPE_W-1:0]       slope;
    logic signed [OUT_W-1:0]  offset;
  } div_word_t;

endpackage

### sv/acp_seg_cell.sv
// One cell of the segment search chain: compares the count with one threshold.
// Depends on acp_pkg for the threshold table and the chain word.
`timescale 1ns / 1ps

module acp_seg_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  acp_pkg::seg_word_t in_word,
  output logic              out_vld,
  output acp_pkg::seg_word_t out_word
);
  import acp_pkg::*;

  localparam logic [COUNT_W-1:0] LIMIT = SEG_LIMIT[IDX];

  logic      hit;
  seg_word_t word_next;

  // The first segment also takes a count equal to its threshold.
  always_comb begin
    if (IDX == 0) begin
      hit = !in_word.found && (in_word.count <= LIMIT);
    end else begin
      hit = !in_word.found && (in_word.count < LIMIT);
    end
    word_next = in_word;
    if (hit) begin
      word_next.found = 1'b1;
      word_next.seg   = SEG_W'(IDX);
    end
  end

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload of this stage.
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

### sv/acp_div_cell.sv
// One cell of the divider chain: a single restoring division step per cycle while en is high.
// Depends on acp_pkg for the chain word and widths.
`timescale 1ns / 1ps

module acp_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  acp_pkg::div_word_t in_word,
  output logic              out_vld,
  output acp_pkg::div_word_t out_word
);
  import acp_pkg::*;

  logic [REM_W:0] trial;
  logic           ge;
  div_word_t      word_next;

  // Bring down the next dividend bit and subtract the slope if it fits.
  always_comb begin
    trial     = {in_word.rem, in_word.low[QUOT_W-1]};
    ge        = (trial >= {1'b0, in_word.slope});
    word_next = in_word;
    if (ge) begin
      word_next.rem = REM_W'(trial - {1'b0, in_word.slope});
    end else begin
      word_next.rem = REM_W'(trial);
    end
    word_next.low = {in_word.low[QUOT_W-2:0], ge};
  end

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload of this stage.
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

### sv/adc_count_to_power_piecewise.sv
// Top level of the ADC-count-to-power calibration block.
// Depends on acp_pkg, acp_seg_cell and acp_div_cell.
`timescale 1ns / 1ps

// Converts a 12-bit power-detector ADC count into RF power in hundredths of a
// dBm using a ten-segment piecewise-linear calibration. One count is taken
// every cycle while adc_ready is high and each count gives one result. The
// path holds NUM_SEGMENTS - 1 cells of threshold search, a register that
// forms count * 1000 and looks up the segment, fifteen restoring division
// cells (one quotient bit each) and the output register, where the intercept
// is added. The first search cell captures the count at the accepting edge
// itself. A two-entry output stage lets the pipeline keep flowing while a
// result waits; while its spare entry is occupied the whole pipeline holds
// and no new count is taken.
module adc_count_to_power_piecewise #(
  parameter int NUM_SEGMENTS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adc_valid,
  output logic                             adc_ready,
  input  logic [acp_pkg::COUNT_W-1:0]      adc_count,
  output logic                             power_valid,
  input  logic                             power_ready,
  output logic signed [acp_pkg::OUT_W-1:0] power_centi_dbm
);
  import acp_pkg::*;

  localparam int SCELLS = NUM_SEGMENTS - 1;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(NUM_SEGMENTS - 1);

  logic                    adv;
  logic [SCELLS:0]         seg_vld;
  seg_word_t               seg_link [SCELLS+1];
  logic [SEG_W-1:0]        seg_final;
  logic [DIV_W-1:0]        dividend;
  logic                    mid_vld;
  div_word_t               mid_word;
  logic [QUOT_W:0]         div_vld;
  div_word_t               div_link [QUOT_W+1];
  logic signed [SUM_W-1:0] sum;
  logic [OUT_W-1:0]        result;
  logic                    incoming;
  logic                    take;
  logic                    skid_vld;
  logic [OUT_W-1:0]        skid_power;

  // The pipeline moves only while the spare output entry is free.
  assign adv       = !skid_vld;
  assign adc_ready = adv;

  // Segment search chain.
  assign seg_vld[0]  = adc_valid;
  assign seg_link[0] = '{count: adc_count, found: 1'b0, seg: '0};

  for (genvar k = 0; k < SCELLS; k++) begin : g_seg
    acp_seg_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (seg_vld[k]),
      .in_word (seg_link[k]),
      .out_vld (seg_vld[k+1]),
      .out_word(seg_link[k+1])
    );
  end

  // Counts at or above the last tested threshold fall into the last segment.
  assign seg_final = seg_link[SCELLS].found ? seg_link[SCELLS].seg : SEG_LAST;
  assign dividend  = DIV_W'(seg_link[SCELLS].count) * DIV_W'(SCALE);

  // Scaling and table lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else if (adv) begin
      mid_vld <= seg_vld[SCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_word.rem    <= REM_W'(dividend[DIV_W-1:QUOT_W]);
      mid_word.low    <= dividend[QUOT_W-1:0];
      mid_word.slope  <= SEG_SLOPE[seg_final];
      mid_word.offset <= SEG_OFFSET[seg_final];
    end
  end

  // Divider chain.
  assign div_vld[0]  = mid_vld;
  assign div_link[0] = mid_word;

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    acp_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (div_vld[j]),
      .in_word (div_link[j]),
      .out_vld (div_vld[j+1]),
      .out_word(div_link[j+1])
    );
  end

  // Quotient plus intercept, kept to the output width.
  assign sum    = $signed({1'b0, div_link[QUOT_W].low}) + SUM_W'(div_link[QUOT_W].offset);
  assign result = sum[OUT_W-1:0];

  assign incoming = adv && div_vld[QUOT_W];
  assign take     = power_valid && power_ready;

  // Output register and spare entry: control.
  always_ff @(posedge clk) begin
    if (rst) begin
      power_valid <= 1'b0;
      skid_vld    <= 1'b0;
    end else if (incoming) begin
      if (!power_valid || power_ready) begin
        power_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      if (skid_vld) begin
        skid_vld <= 1'b0;
      end else begin
        power_valid <= 1'b0;
      end
    end
  end

  // Output register and spare entry: payload.
  always_ff @(posedge clk) begin
    if (incoming) begin
      if (!power_valid || power_ready) begin
        power_centi_dbm <= result;
      end else begin
        skid_power <= result;
      end
    end else if (take && skid_vld) begin
      power_centi_dbm <= skid_power;
    end
  end

endmodule
